/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_CLK(lbl, clk, rst, !(cond), msg)
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

/* hw/rtl/u2a_pkg.sv */
// ----------------------------------------------------------------------------
// u2a_pkg
// Types, constants and helpers for the binary to ASCII digit converter.
// ----------------------------------------------------------------------------
package u2a_pkg;

   localparam int VALUE_W = 32;
   localparam int CHAR_W  = 7;
   localparam int DIGIT_W = 4;
   localparam int PROD_W  = 2 * VALUE_W;

   // floor(n / 10) == (n * 0xCCCCCCCD) >> 35 for every 32-bit n
   localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int DIV10_SHIFT = 35;
   localparam int HEX_SHIFT   = 4;

   localparam logic [DIGIT_W-1:0] DECIMAL_RADIX = 4'd10;
   localparam logic [CHAR_W-1:0]  DIGIT_ZERO    = 7'd48;
   localparam logic [CHAR_W-1:0]  LETTER_A      = 7'd97;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CONVERT,
      S_EMIT
   } u2a_state_type;

   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] num;
      logic               is_hex;
   } u2a_div_req_type;

   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] quotient;
      logic [CHAR_W-1:0]  code;
   } u2a_div_rsp_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] code;
      if (d >= DECIMAL_RADIX) begin
         code = LETTER_A + CHAR_W'(d) - CHAR_W'(DECIMAL_RADIX);
      end else begin
         code = DIGIT_ZERO + CHAR_W'(d);
      end
      return code;
   endfunction

endpackage

/* hw/rtl/u2a_req_if.sv */
// ----------------------------------------------------------------------------
// u2a_req_if
// Request channel: one value to convert and its base select per word.
// ----------------------------------------------------------------------------
interface u2a_req_if;
   logic                          valid;
   logic                          ready;
   logic [u2a_pkg::VALUE_W-1:0]   value;
   logic                          is_hex;

   modport source (output valid, output value, output is_hex, input ready);
   modport sink   (input valid, input value, input is_hex, output ready);
endinterface

/* hw/rtl/u2a_rsp_if.sv */
// ----------------------------------------------------------------------------
// u2a_rsp_if
// Response channel: one ASCII digit and a last flag per word.
// ----------------------------------------------------------------------------
interface u2a_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [u2a_pkg::CHAR_W-1:0]    char_code;
   logic                          last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

/* hw/rtl/unsigned_to_ascii_digits.sv */
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits
// Binary to ASCII decimal/hex digits, most significant first, no leading zeros.
// ----------------------------------------------------------------------------
// Divide steps run first, one digit per cycle from the shared divide unit;
//   readout follows at one word per cycle while the response channel is ready.
// A new request is taken while the final digit still waits in the output register.
// Reset (synchronous, active high) idles the sequencer and drops the output word.
`include "assert_macros.svh"

module unsigned_to_ascii_digits #(
   parameter int MAX_DIGITS = 10
) (
   input  logic       clock,
   input  logic       reset,
   u2a_req_if.sink    req_ch,
   u2a_rsp_if.source  rsp_ch
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = $clog2(MAX_DIGITS);

   u2a_pkg::u2a_state_type      state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            rd_idx_ff, rd_idx_in;
   logic                        hex_ff, hex_in;
   logic                        out_valid_ff, out_valid_in;
   logic [u2a_pkg::CHAR_W-1:0]  out_char_ff, out_char_in;
   logic                        out_last_ff, out_last_in;

   u2a_pkg::u2a_div_req_type    div_req;
   u2a_pkg::u2a_div_rsp_type    div_rsp;
   logic                        req_ready;
   logic                        wr_en;
   logic                        load_out;
   logic                        conv_end;
   logic [CNT_W-1:0]            count_inc;
   logic [u2a_pkg::CHAR_W-1:0]  rd_data;

   // shared divide step: one quotient/remainder per cycle
   u2a_div_unit u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // digits land low first at count, read back from the top down;
   // read is registered, so the buffer is addressed with the next index
   u2a_digit_buf #(
      .WIDTH (u2a_pkg::CHAR_W),
      .DEPTH (MAX_DIGITS)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (div_rsp.code),
      .rd_addr (rd_idx_in),
      .rd_data (rd_data)
   );

   assign count_inc = count_ff + CNT_W'(1);
   // stop on zero quotient, or when the buffer is full (high digits dropped)
   assign conv_end  = (div_rsp.quotient == '0) || (count_inc == CNT_W'(MAX_DIGITS));

   // sequencer outputs
   always_comb begin
      req_ready      = 1'b0;
      div_req.start  = 1'b0;
      div_req.num    = div_rsp.quotient;
      div_req.is_hex = hex_ff;
      wr_en          = 1'b0;
      load_out       = 1'b0;
      case (state_ff)
         u2a_pkg::S_IDLE: begin
            req_ready      = 1'b1;
            div_req.start  = req_ch.valid;
            div_req.num    = req_ch.value;
            div_req.is_hex = req_ch.is_hex;
         end
         u2a_pkg::S_CONVERT: begin
            wr_en         = div_rsp.valid;
            div_req.start = div_rsp.valid && !conv_end;
         end
         u2a_pkg::S_EMIT: begin
            load_out = !out_valid_ff || rsp_ch.ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         u2a_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               state_in = u2a_pkg::S_CONVERT;
            end
         end
         u2a_pkg::S_CONVERT: begin
            if (div_rsp.valid && conv_end) begin
               state_in = u2a_pkg::S_EMIT;
            end
         end
         u2a_pkg::S_EMIT: begin
            if (load_out && (rd_idx_ff == '0)) begin
               state_in = u2a_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = u2a_pkg::S_IDLE;
         end
      endcase
   end

   // counters and output register
   always_comb begin
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      hex_in       = hex_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      if (req_ready && req_ch.valid) begin
         count_in = '0;
         hex_in   = req_ch.is_hex;
      end
      if (wr_en) begin
         count_in = count_inc;
         if (conv_end) begin
            rd_idx_in = count_ff[IDX_W-1:0];   // top digit
         end
      end
      if (load_out) begin
         out_valid_in = 1'b1;
         out_char_in  = rd_data;
         out_last_in  = (rd_idx_ff == '0);
         // index parks at zero after the last digit
         if (rd_idx_ff != '0) begin
            rd_idx_in = rd_idx_ff - IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= u2a_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      count_ff    <= count_in;
      rd_idx_ff   <= rd_idx_in;
      hex_ff      <= hex_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.char_code = out_char_ff;
   assign rsp_ch.last      = out_last_ff;

   `ASSERT_CLK(a_count_in_range, clock, reset,
      state_ff == u2a_pkg::S_CONVERT |-> count_ff < CNT_W'(MAX_DIGITS),
      "digit count overran buffer")
   `ASSERT_CLK(a_rd_idx_in_range, clock, reset,
      state_ff == u2a_pkg::S_EMIT |-> CNT_W'(rd_idx_ff) < count_ff,
      "readout index past stored digits")
   `ASSERT_CLK(a_accept_starts_div, clock, reset,
      req_ch.valid && req_ch.ready |=> state_ff == u2a_pkg::S_CONVERT && div_rsp.valid,
      "request did not start conversion")
   `ASSERT_CLK(a_char_is_digit, clock, reset,
      out_valid_ff |-> (out_char_ff >= 7'd48 && out_char_ff <= 7'd57) ||
                       (out_char_ff >= 7'd97 && out_char_ff <= 7'd102),
      "output is not a digit")

endmodule

/* hw/rtl/u2a_div_unit.sv */
// ----------------------------------------------------------------------------
// u2a_div_unit
// Shared divide-by-radix step: quotient and ASCII remainder, one per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u2a_div_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  u2a_pkg::u2a_div_req_type  div_req,
   output u2a_pkg::u2a_div_rsp_type  div_rsp
);

   logic                              valid_ff, valid_in;
   logic                              hex_ff, hex_in;
   logic [u2a_pkg::VALUE_W-1:0]       num_ff, num_in;
   logic [u2a_pkg::PROD_W-1:0]        prod_ff, prod_in;

   logic [u2a_pkg::VALUE_W-1:0]       quot_w;
   logic [u2a_pkg::VALUE_W-1:0]       ten_q_w;
   logic [u2a_pkg::VALUE_W-1:0]       diff_w;
   logic [u2a_pkg::DIGIT_W-1:0]       rem_w;

   // reciprocal multiply registered, quotient and remainder next cycle
   always_comb begin
      valid_in = div_req.start;
      hex_in   = div_req.start ? div_req.is_hex : hex_ff;
      num_in   = div_req.start ? div_req.num : num_ff;
      prod_in  = div_req.start ?
                 ({{u2a_pkg::VALUE_W{1'b0}}, div_req.num} *
                  {{u2a_pkg::VALUE_W{1'b0}}, u2a_pkg::DIV10_RECIP}) : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      hex_ff  <= hex_in;
      num_ff  <= num_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      if (hex_ff) begin
         quot_w = num_ff >> u2a_pkg::HEX_SHIFT;
      end else begin
         quot_w = u2a_pkg::VALUE_W'(prod_ff >> u2a_pkg::DIV10_SHIFT);
      end
      ten_q_w = (quot_w << 3) + (quot_w << 1);
      diff_w  = num_ff - ten_q_w;
      rem_w   = hex_ff ? num_ff[u2a_pkg::DIGIT_W-1:0] : diff_w[u2a_pkg::DIGIT_W-1:0];
   end

   assign div_rsp.valid    = valid_ff;
   assign div_rsp.quotient = quot_w;
   assign div_rsp.code     = u2a_pkg::digit_to_ascii(rem_w);

   `ASSERT_CLK(a_dec_rem_below_ten, clock, reset, valid_ff && !hex_ff |-> rem_w < u2a_pkg::DECIMAL_RADIX, "decimal remainder out of range")
   `ASSERT_CLK(a_dec_exact, clock, reset, valid_ff && !hex_ff |-> diff_w < 32'd10, "reciprocal quotient off by one")
   `ASSERT_CLK(a_start_gives_result, clock, reset, div_req.start |=> valid_ff, "divide step result missing")

endmodule

/* hw/rtl/u2a_digit_buf.sv */
// ----------------------------------------------------------------------------
// u2a_digit_buf
// Generic RAM: one write port, registered read, a write to the read address
// shows up on the read data at the same edge.
// ----------------------------------------------------------------------------
module u2a_digit_buf #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [WIDTH-1:0]             rd_data
);

   logic [WIDTH-1:0] buf_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_ff[wr_addr] <= wr_data;
      end
      // write-first on an address match
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= buf_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* verif/tb_unsigned_to_ascii_digits.sv */
// ----------------------------------------------------------------------------
// tb_unsigned_to_ascii_digits
// Self-checking bench for the binary to ASCII digit converter. A directed
// table covers zero, single digits, digit-count boundaries and the full
// 32-bit range. A random run follows, with idle and stall bursts on both
// channels. Every digit word is checked in order against the expected digit
// string: the directed row's own, else one from a digit-string predictor.
// ----------------------------------------------------------------------------
module tb_unsigned_to_ascii_digits;
   timeunit 1ns;
   timeprecision 1ps;

   // base select codes on the is_hex field
   localparam logic BASE_DEC = 1'b0;
   localparam logic BASE_HEX = 1'b1;

   localparam int RADIX_DEC = 10;
   localparam int RADIX_HEX = 16;

   localparam logic [u2a_pkg::CHAR_W-1:0] ASCII_ZERO    = 7'd48;
   localparam logic [u2a_pkg::CHAR_W-1:0] ASCII_LOWER_A = 7'd97;

   localparam int MAX_DIGITS = 10;     // DUT default, nothing gets dropped

   localparam int RANDOM_WORDS    = 137;
   localparam int QUIET_TAIL      = 30;    // last random words run with no idling
   localparam int HOLD_AT         = 40;    // random word that triggers the long stall
   localparam int PAUSE_AT        = 100;   // random word held back until drained
   localparam int RSP_HOLD_CYCLES = 200;
   localparam int DRAIN_LIMIT     = 4000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int LIMIT_NS        = 2_000_000;

   localparam int NUM_ROWS = 23;

   // one digit word on the response channel
   typedef struct packed {
      logic [u2a_pkg::CHAR_W-1:0] char_code;
      logic                       last;
   } digit_word_type;

   // directed stimulus row; an empty digit string means "use the predictor"
   typedef struct {
      logic [u2a_pkg::VALUE_W-1:0] value;
      logic                        is_hex;
      string                       digits;
   } stim_row_type;

   logic clock;
   logic reset;

   u2a_req_if req_bus ();
   u2a_rsp_if rsp_bus ();

   unsigned_to_ascii_digits DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // digit words still owed by the DUT, oldest first
   digit_word_type pending_digits [$];

   int  error_count    = 0;
   int  digits_checked = 0;
   int  words_dec      = 0;
   int  words_hex      = 0;
   bit  tail_quiet     = 1'b0;
   bit  rsp_hold_req   = 1'b0;
   bit  rsp_hold_seen  = 1'b0;
   bit  drain_paused   = 1'b0;

   stim_row_type stim_table [NUM_ROWS] = '{
      '{32'h0000_0000, BASE_DEC, "0"},
      '{32'h0000_0000, BASE_HEX, "0"},
      '{32'h0000_0001, BASE_DEC, "1"},
      '{32'h0000_0001, BASE_HEX, "1"},
      '{32'd9,         BASE_DEC, "9"},
      '{32'd10,        BASE_DEC, "10"},
      '{32'h0000_000F, BASE_HEX, "f"},
      '{32'h0000_0010, BASE_HEX, "10"},
      '{32'hFFFF_FFFF, BASE_DEC, "4294967295"},
      '{32'hFFFF_FFFF, BASE_HEX, "ffffffff"},
      '{32'h8000_0000, BASE_DEC, "2147483648"},
      '{32'h8000_0000, BASE_HEX, "80000000"},
      '{32'd999999999, BASE_DEC, "999999999"},
      '{32'd1000000000, BASE_DEC, "1000000000"},
      '{32'h0FFF_FFFF, BASE_HEX, "fffffff"},
      '{32'h1000_0000, BASE_HEX, "10000000"},
      '{32'h00AB_CDEF, BASE_HEX, "abcdef"},
      '{32'hDEAD_BEEF, BASE_HEX, "deadbeef"},
      '{32'h5555_5555, BASE_HEX, "55555555"},
      '{32'hAAAA_AAAA, BASE_HEX, "aaaaaaaa"},
      '{32'd12345,     BASE_DEC, ""},
      '{32'h7FFF_FFFF, BASE_DEC, ""},
      '{32'h0012_3400, BASE_HEX, ""}
   };

   // ------------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Digit-string predictor: peel digits off the low end into a buffer,
   // stop at zero or when the buffer is full, then queue them most
   // significant first with last on the final one.
   // ------------------------------------------------------------------------
   function automatic void predict_digits(input logic [u2a_pkg::VALUE_W-1:0] value,
                                          input logic is_hex);
      logic [u2a_pkg::VALUE_W-1:0] rest;
      int unsigned                 radix;
      int unsigned                 d;
      logic [u2a_pkg::CHAR_W-1:0]  codes [MAX_DIGITS];
      int                          n;
      digit_word_type              w;
      rest  = value;
      radix = (is_hex == BASE_HEX) ? RADIX_HEX : RADIX_DEC;
      n     = 0;
      do begin
         d = rest % radix;
         if (d >= RADIX_DEC) begin
            codes[n] = ASCII_LOWER_A + u2a_pkg::CHAR_W'(d - RADIX_DEC);
         end else begin
            codes[n] = ASCII_ZERO + u2a_pkg::CHAR_W'(d);
         end
         n++;
         rest = rest / radix;
      end while (rest != 0 && n < MAX_DIGITS);
      for (int k = n - 1; k >= 0; k--) begin
         w.char_code = codes[k];
         w.last      = (k == 0);
         pending_digits.push_back(w);
      end
   endfunction

   // random value with a spread of digit counts; full-width draws keep
   // every bit of the field toggling
   function automatic logic [u2a_pkg::VALUE_W-1:0] random_value();
      logic [u2a_pkg::VALUE_W-1:0] v;
      int                          width;
      v = $urandom;
      case ($urandom_range(0, 7))
         0, 1: ;                                  // full 32-bit draw
         2: v = 32'h0;
         3: v = 32'hFFFF_FFFF >> $urandom_range(0, 31);  // all-ones runs
         default: begin
            width = $urandom_range(1, 32);
            v = v >> (u2a_pkg::VALUE_W - width);
         end
      endcase
      return v;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver. Inputs move on the falling edge, acceptance is seen on
   // the rising edge. Each falling edge gets one assignment to valid, so a
   // back-to-back word never blips valid low.
   // ------------------------------------------------------------------------
   task automatic offer_word(input logic [u2a_pkg::VALUE_W-1:0] value,
                             input logic is_hex, input string typed);
      int             gap;
      byte            ch;
      digit_word_type w;
      if (!tail_quiet && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 10);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_bus.valid  <= 1'b1;
      req_bus.value  <= value;
      req_bus.is_hex <= is_hex;
      do @(posedge clock); while (!req_bus.ready);
      // word taken at this edge: queue what it must produce
      if (typed.len() != 0) begin
         for (int i = 0; i < typed.len(); i++) begin
            ch          = typed[i];
            w.char_code = ch[u2a_pkg::CHAR_W-1:0];
            w.last      = (i == typed.len() - 1);
            pending_digits.push_back(w);
         end
      end else begin
         predict_digits(value, is_hex);
      end
      if (is_hex == BASE_HEX) words_hex++;
      else words_dec++;
   endtask

   // ------------------------------------------------------------------------
   // Response ready: random runs of ready and stall bursts. One long hold
   // on request, counted here, so the DUT backs up into its input.
   // ------------------------------------------------------------------------
   initial begin : rsp_throttle
      int run_len;
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            repeat (RSP_HOLD_CYCLES) begin
               @(negedge clock);
               rsp_bus.ready <= 1'b0;
            end
            rsp_hold_seen = 1'b1;
         end else if (tail_quiet) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            run_len = $urandom_range(1, 10);
            repeat (run_len) begin
               @(negedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end else begin
            run_len = $urandom_range(1, 30);
            repeat (run_len) begin
               @(negedge clock);
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response checker: every accepted digit word against the oldest owed one
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : digit_check
      digit_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_digits.size() == 0) begin
            $error("unexpected digit word: char_code %0d last %0b",
                   rsp_bus.char_code, rsp_bus.last);
            error_count++;
         end else begin
            want = pending_digits.pop_front();
            digits_checked++;
            if (rsp_bus.char_code !== want.char_code) begin
               $error("char_code: expected %0d, got %0d", want.char_code, rsp_bus.char_code);
               error_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_bus.last);
               error_count++;
            end
         end
      end
   end

   // hard stop if the DUT wedges
   initial begin
      #(LIMIT_NS);
      $display("tb_unsigned_to_ascii_digits: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      int drain;
      req_bus.valid  = 1'b0;
      req_bus.value  = '0;
      req_bus.is_hex = BASE_DEC;
      reset          = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (stim_table[i]) begin
         offer_word(stim_table[i].value, stim_table[i].is_hex, stim_table[i].digits);
      end

      // random words
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == HOLD_AT) rsp_hold_req = 1'b1;     // sender keeps offering through it
         if (n == PAUSE_AT) begin
            // drop valid, then hold the next word back until every owed digit is out
            @(negedge clock);
            req_bus.valid <= 1'b0;
            while (pending_digits.size() != 0) @(posedge clock);
            drain_paused = 1'b1;
         end
         if (n == RANDOM_WORDS - QUIET_TAIL) tail_quiet = 1'b1;
         offer_word(random_value(), $urandom_range(0, 1), "");
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      // drain, then let any stray word show up
      drain = 0;
      while (pending_digits.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_digits.size() != 0) begin
         $error("%0d digit words never arrived", pending_digits.size());
         error_count++;
      end

      $display("Converted %0d words (%0d base 10, %0d base 16), %0d digit words checked.",
               words_dec + words_hex, words_dec, words_hex, digits_checked);
      $display("Long output stall done: %0b, full drain pause done: %0b.",
               rsp_hold_seen, drain_paused);
      if (error_count == 0) begin
         $display("tb_unsigned_to_ascii_digits: done, clean");
      end else begin
         $display("tb_unsigned_to_ascii_digits: done, errors");
      end
      $finish;
   end

endmodule
